### hdl/assert_macros.svh
// Assertion macros shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property that is switched off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("RTL assertion failed");

// Clocked property that must also hold during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("RTL assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

### hdl/lcsld_pkg.sv
package lcsld_pkg;

	localparam int MAX_PATTERN = 64;
	localparam int SYM_W = 8;
	localparam int CNT_W = $clog2(MAX_PATTERN + 1);
	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int OUT_LEN_W = 7;
	localparam int OUT_LEN_MAX = 127;

	typedef enum logic [1:0] {
		REQ_START  = 2'd0,
		REQ_APPEND = 2'd1,
		REQ_TEXT   = 2'd2
	} req_t;

	// One text symbol travelling down the row of cells.
	typedef struct packed {
		logic             valid;
		logic             last;
		logic             carry;
		logic [SYM_W-1:0] sym;
	} token_t;

	function automatic logic [OUT_LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
		logic [OUT_LEN_W-1:0] res;
		if (32'(len) > 32'(OUT_LEN_MAX)) begin
			res = OUT_LEN_W'(OUT_LEN_MAX);
		end else begin
			res = OUT_LEN_W'(len);
		end
		return res;
	endfunction

endpackage

### hdl/lcsld_req_if.sv
interface lcsld_req_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   req_type;
	logic [lcsld_pkg::SYM_W-1:0]  symbol;
	logic                         is_last;

	modport source (output valid, req_type, symbol, is_last, input ready);
	modport sink (input valid, req_type, symbol, is_last, output ready);
endinterface

### hdl/lcsld_res_if.sv
interface lcsld_res_if;
	logic                             valid;
	logic                             ready;
	logic [lcsld_pkg::OUT_LEN_W-1:0]  lcs_length;
	logic                             pattern_overflow;

	modport source (output valid, lcs_length, pattern_overflow, input ready);
	modport sink (input valid, lcs_length, pattern_overflow, output ready);
endinterface

### hdl/lcsld_cell.sv
module lcsld_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic                        active,
	input  logic                        load,
	input  logic                        clear,
	input  logic [lcsld_pkg::SYM_W-1:0] load_sym,
	input  lcsld_pkg::token_t           tok_in,
	output lcsld_pkg::token_t           tok_out
);
	import lcsld_pkg::*;

	logic [SYM_W-1:0] sym_q;
	logic             row_q;
	logic             tok_valid_q;
	logic             tok_last_q;
	logic             tok_carry_q;
	logic [SYM_W-1:0] tok_sym_q;
	logic             eq;
	logic             nrow;
	logic             ncarry;

	always_comb begin
		eq     = (sym_q == tok_in.sym);
		nrow   = (eq | row_q) & ~tok_in.carry;
		ncarry = (eq | tok_in.carry) & ~row_q;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sym_q <= load_sym;
		end
	end

	// The final text symbol leaves every row cleared behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= 1'b0;
		end else if (clear || load) begin
			row_q <= 1'b0;
		end else if (advance && tok_in.valid) begin
			if (tok_in.last) begin
				row_q <= 1'b0;
			end else if (active) begin
				row_q <= nrow;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else if (advance) begin
			tok_valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tok_last_q  <= tok_in.last;
			tok_sym_q   <= tok_in.sym;
			tok_carry_q <= active ? ncarry : tok_in.carry;
		end
	end

	always_comb begin
		tok_out.valid = tok_valid_q;
		tok_out.last  = tok_last_q;
		tok_out.carry = tok_carry_q;
		tok_out.sym   = tok_sym_q;
	end

endmodule

### hdl/lcs_length_difference_dp.sv
// Channel  Direction  Word contents
// req      in         req_type, symbol, is_last
// res      out        lcs_length, pattern_overflow
//
// Text words stream back to back through a row of MAX_PATTERN cells, one per cycle
// while the row is not stalled. A result is registered after the final text word
// has passed through every cell. Pattern words wait until no text word is left in
// the row, which takes longer while the row is stalled.
// Reset clears the pattern count, row bits, length and overflow flag at once.
// A result held in the output register stalls the row only when the next final
// text word reaches the end of the row.
`include "assert_macros.svh"

module lcs_length_difference_dp (
	input  logic clk,
	input  logic arst_n,
	lcsld_req_if.sink   req,
	lcsld_res_if.source res
);
	import lcsld_pkg::*;

	// Each cell holds one pattern symbol and its row-difference bit. A text
	// symbol enters the first cell with a zero carry and moves one cell per
	// cycle while the row advances, so the carry ripples down the pattern as a
	// skewed wavefront and the next text symbol can follow right behind it.

	token_t                   link [MAX_PATTERN+1];
	logic [MAX_PATTERN-1:0]   busy;
	logic [MAX_PATTERN-1:0]   active;
	logic [MAX_PATTERN-1:0]   load;
	logic                     chain_empty;
	logic                     advance;
	logic                     rdy;
	logic                     req_acc;
	logic                     acc_start;
	logic                     acc_append;
	logic                     acc_text;
	logic                     wr_en;
	logic [CNT_W-1:0]         wr_idx;
	logic [CNT_W-1:0]         cnt_q;
	logic [LEN_W-1:0]         len_q;
	logic [LEN_W-1:0]         len_next;
	logic                     ovf_q;
	logic                     res_valid_q;
	logic [OUT_LEN_W-1:0]     res_len_q;
	logic                     res_ovf_q;
	logic                     tail_take;
	token_t                   tail;

	assign tail        = link[MAX_PATTERN];
	assign chain_empty = ~|busy;

	// The row halts only when a final word would land on an unread result.
	assign advance = !(tail.valid && tail.last && res_valid_q && !res.ready);

	always_comb begin
		case (req.req_type) inside
			REQ_START, REQ_APPEND: rdy = chain_empty;
			REQ_TEXT:              rdy = advance;
			default:               rdy = 1'b1;
		endcase
	end

	assign req.ready  = rdy;
	assign req_acc    = req.valid && rdy;
	assign acc_start  = req_acc && (req.req_type == REQ_START);
	assign acc_append = req_acc && (req.req_type == REQ_APPEND);
	assign acc_text   = req_acc && (req.req_type == REQ_TEXT);

	// A start always writes cell zero; an append writes the next free cell.
	assign wr_idx = acc_start ? '0 : cnt_q;
	assign wr_en  = acc_start || (acc_append && (cnt_q < CNT_W'(MAX_PATTERN)));

	always_comb begin
		link[0].valid = acc_text;
		link[0].last  = req.is_last;
		link[0].carry = 1'b0;
		link[0].sym   = req.symbol;
	end

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		assign active[i] = CNT_W'(i) < cnt_q;
		assign load[i]   = wr_en && (wr_idx == CNT_W'(i));
		assign busy[i]   = link[i+1].valid;

		lcsld_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.active   (active[i]),
			.load     (load[i]),
			.clear    (acc_start),
			.load_sym (req.symbol),
			.tok_in   (link[i]),
			.tok_out  (link[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (acc_start) begin
			cnt_q <= CNT_W'(1);
			ovf_q <= 1'b0;
		end else if (acc_append) begin
			if (cnt_q < CNT_W'(MAX_PATTERN)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// The carry that leaves the last cell adds one to the running length.
	assign len_next  = len_q + LEN_W'(tail.carry);
	assign tail_take = advance && tail.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (acc_start) begin
			len_q <= '0;
		end else if (tail_take) begin
			len_q <= tail.last ? '0 : len_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (tail_take && tail.last) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tail_take && tail.last) begin
			res_len_q <= sat_len(len_next);
			res_ovf_q <= ovf_q;
		end
	end

	assign res.valid            = res_valid_q;
	assign res.lcs_length       = res_len_q;
	assign res.pattern_overflow = res_ovf_q;

	`ASSERT_CLK(a_pat_when_empty, clk, arst_n, (acc_start || acc_append) |-> chain_empty)
	`ASSERT_CLK(a_cnt_range, clk, arst_n, cnt_q <= CNT_W'(MAX_PATTERN))
	`ASSERT_CLK(a_len_bound, clk, arst_n, len_q <= cnt_q)
	`ASSERT_CLK(a_ovf_full, clk, arst_n, ovf_q |-> (cnt_q == CNT_W'(MAX_PATTERN)))

endmodule
